[design/ptc_pkg.sv]
// ptc_pkg: payload types and timing constants for the pulse time calculator
// no dependencies; imported by every ptc module
`default_nettype none

package ptc_pkg;

  typedef struct packed {
    logic [39:0] start_seconds;
    logic [26:0] start_coarse;
    logic [11:0] start_fraction;
    logic [39:0] length_ps;
    logic [43:0] period_ps;
  } ptc_in_t;

  typedef struct packed {
    logic [39:0] end_seconds;
    logic [26:0] end_coarse;
    logic [11:0] end_fraction;
    logic [3:0]  period_seconds;
    logic [26:0] period_coarse;
    logic [11:0] period_fraction;
  } ptc_out_t;

  typedef struct packed {
    logic [39:0] sec;
    logic [26:0] coarse;
    logic [11:0] frac;
  } ptc_time_t;

  // 8 ns ticks in one second
  localparam logic [26:0] TICKS_PER_SEC = 27'd125000000;
  // 8000 ps = 64 * 125
  localparam logic [6:0]  DIV125        = 7'd125;
  // floor(2^40 / 125)
  localparam logic [33:0] RECIP_125     = 34'd8796093022;
  // ceil(2^26 / 125), exact for 16-bit operands
  localparam logic [19:0] FRAC_RECIP    = 20'd536871;
  // 10^12 ps = 2^12 * 244140625
  localparam logic [27:0] PSEC_DIVISOR  = 28'd244140625;
  // floor(2^32 / 244140625)
  localparam logic [4:0]  PSEC_RECIP    = 5'd17;

endpackage

`default_nettype wire

[design/ptc_div8000.sv]
// ptc_div8000: four-stage divide of a 40-bit ps value by 8000
// gives ticks and the 1/4096 tick fraction; uses ptc_pkg
`default_nettype none

module ptc_div8000 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [39:0] dividend,
  output logic        out_valid,
  output logic [27:0] quot,
  output logic [11:0] frac
);
  import ptc_pkg::*;

  logic [3:0]  vld;
  logic [50:0] pp_hi;
  logic [50:0] pp_lo;
  logic [7:0]  x8_1;
  logic [5:0]  low6_1;
  logic [67:0] prod;
  logic [27:0] q0_2;
  logic [7:0]  x8_2;
  logic [5:0]  low6_2;
  logic [14:0] qm;
  logic [7:0]  r8;
  logic [27:0] q_next;
  logic [6:0]  rm;
  logic [27:0] q3;
  logic [12:0] y3;
  logic [32:0] fp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  assign out_valid = vld[3];

  // stage 1: partial products of (dividend >> 6) * reciprocal of 125
  always_ff @(posedge clk) begin
    pp_hi  <= 51'(dividend[39:23]) * 51'(RECIP_125);
    pp_lo  <= 51'(dividend[22:6]) * 51'(RECIP_125);
    x8_1   <= dividend[13:6];
    low6_1 <= dividend[5:0];
  end

  // stage 2: estimated quotient, low by at most one
  assign prod = {pp_hi, 17'd0} + 68'(pp_lo);

  always_ff @(posedge clk) begin
    q0_2   <= prod[67:40];
    x8_2   <= x8_1;
    low6_2 <= low6_1;
  end

  // stage 3: remainder fits 8 bits, one correction
  always_comb begin
    qm = 15'(q0_2[7:0]) * 15'(DIV125);
    r8 = x8_2 - qm[7:0];
    if (r8 >= {1'b0, DIV125}) begin
      q_next = q0_2 + 28'd1;
      rm     = 7'(r8 - {1'b0, DIV125});
    end else begin
      q_next = q0_2;
      rm     = r8[6:0];
    end
  end

  always_ff @(posedge clk) begin
    q3 <= q_next;
    y3 <= {rm, low6_2};
  end

  // stage 4: fraction = floor(rem * 64 / 125)
  assign fp = 33'(y3) * 33'(FRAC_RECIP);

  always_ff @(posedge clk) begin
    quot <= q3;
    frac <= fp[31:20];
  end

endmodule

`default_nettype wire

[design/ptc_psec.sv]
// ptc_psec: three-stage split of a 44-bit period into whole seconds and ps remainder
// uses ptc_pkg
`default_nettype none

module ptc_psec (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [43:0] period,
  output logic        out_valid,
  output logic [3:0]  seconds,
  output logic [39:0] rem
);
  import ptc_pkg::*;

  logic [2:0]  vld;
  logic [36:0] est;
  logic [4:0]  q0_1;
  logic [31:0] x_1;
  logic [11:0] lo_1;
  logic [32:0] qd;
  logic [31:0] rx_full;
  logic [4:0]  q0_2;
  logic [28:0] rx_2;
  logic [11:0] lo_2;
  logic [4:0]  q_next;
  logic [28:0] rx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_valid};
    end
  end

  assign out_valid = vld[2];

  // stage 1: estimate seconds from (period >> 12) / 244140625
  assign est = 37'(period[43:12]) * 37'(PSEC_RECIP);

  always_ff @(posedge clk) begin
    q0_1 <= est[36:32];
    x_1  <= period[43:12];
    lo_1 <= period[11:0];
  end

  // stage 2: partial remainder
  assign qd      = 33'(q0_1) * 33'(PSEC_DIVISOR);
  assign rx_full = x_1 - qd[31:0];

  always_ff @(posedge clk) begin
    q0_2 <= q0_1;
    rx_2 <= rx_full[28:0];
    lo_2 <= lo_1;
  end

  // stage 3: one correction
  always_comb begin
    if (rx_2 >= 29'(PSEC_DIVISOR)) begin
      q_next  = q0_2 + 5'd1;
      rx_next = rx_2 - 29'(PSEC_DIVISOR);
    end else begin
      q_next  = q0_2;
      rx_next = rx_2;
    end
  end

  always_ff @(posedge clk) begin
    seconds <= q_next[3:0];
    rem     <= {rx_next[27:0], lo_2};
  end

endmodule

`default_nettype wire

[design/pulse_time_calculator_top.sv]
// pulse_time_calculator_top: end time and period split of one pulse, fully pipelined
// uses ptc_pkg, ptc_psec, ptc_div8000
// done is high for exactly one cycle per transfer, driven from the output register
// throughput: one item per cycle; busy is always low, the receiver cannot stall
// depth set by period path: 3 stages seconds split then 4 stages divide by 8000
// reset clears all valid bits; no done until new items arrive
`default_nettype none

module pulse_time_calculator_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ptc_pkg::ptc_in_t  item,
  output logic              done,
  output ptc_pkg::ptc_out_t result
);
  import ptc_pkg::*;

  logic        xfer;
  ptc_time_t   st_pipe [4];
  logic        len_dv;
  logic [27:0] len_quot;
  logic [11:0] len_frac;
  logic        ps_dv;
  logic [3:0]  ps_sec;
  logic [39:0] ps_rem;
  logic        per_dv;
  logic [27:0] per_quot;
  logic [11:0] per_frac;
  logic [3:0]  psec_pipe [4];
  logic [12:0] fsum;
  logic [28:0] csum_next;
  logic [2:0]  ev;
  logic [39:0] e1_sec;
  logic [28:0] e1_csum;
  logic [11:0] e1_frac;
  logic [39:0] e2_sec;
  logic [28:0] e2_csum;
  logic [11:0] e2_frac;
  logic [39:0] e3_sec;
  logic [28:0] e3_csum;
  logic [11:0] e3_frac;

  assign busy = 1'b0;
  assign xfer = start & ~busy;

  // start time rides along with the length divide
  always_ff @(posedge clk) begin
    st_pipe[0] <= '{sec: item.start_seconds, coarse: item.start_coarse,
                    frac: item.start_fraction};
    for (int i = 1; i < 4; i++) begin
      st_pipe[i] <= st_pipe[i-1];
    end
  end

  ptc_div8000 u_len_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (xfer),
    .dividend  (item.length_ps),
    .out_valid (len_dv),
    .quot      (len_quot),
    .frac      (len_frac)
  );

  ptc_psec u_psec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (xfer),
    .period    (item.period_ps),
    .out_valid (ps_dv),
    .seconds   (ps_sec),
    .rem       (ps_rem)
  );

  ptc_div8000 u_per_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ps_dv),
    .dividend  (ps_rem),
    .out_valid (per_dv),
    .quot      (per_quot),
    .frac      (per_frac)
  );

  always_ff @(posedge clk) begin
    psec_pipe[0] <= ps_sec;
    for (int i = 1; i < 4; i++) begin
      psec_pipe[i] <= psec_pipe[i-1];
    end
  end

  // end time: fraction add with carry, then two coarse reductions
  assign fsum      = {1'b0, st_pipe[3].frac} + {1'b0, len_frac};
  assign csum_next = 29'(st_pipe[3].coarse) + 29'(len_quot) + 29'(fsum[12]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= '0;
    end else begin
      ev <= {ev[1:0], len_dv};
    end
  end

  always_ff @(posedge clk) begin
    e1_sec  <= st_pipe[3].sec;
    e1_csum <= csum_next;
    e1_frac <= fsum[11:0];
  end

  always_ff @(posedge clk) begin
    e2_frac <= e1_frac;
    if (e1_csum >= 29'(TICKS_PER_SEC)) begin
      e2_csum <= e1_csum - 29'(TICKS_PER_SEC);
      e2_sec  <= e1_sec + 40'd1;
    end else begin
      e2_csum <= e1_csum;
      e2_sec  <= e1_sec;
    end
  end

  always_ff @(posedge clk) begin
    e3_frac <= e2_frac;
    if (e2_csum >= 29'(TICKS_PER_SEC)) begin
      e3_csum <= e2_csum - 29'(TICKS_PER_SEC);
      e3_sec  <= e2_sec + 40'd1;
    end else begin
      e3_csum <= e2_csum;
      e3_sec  <= e2_sec;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ev[2];
    end
  end

  always_ff @(posedge clk) begin
    result.end_seconds     <= e3_sec;
    result.end_coarse      <= e3_csum[26:0];
    result.end_fraction    <= e3_frac;
    result.period_seconds  <= psec_pipe[3];
    result.period_coarse   <= per_quot[26:0];
    result.period_fraction <= per_frac;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    xfer |-> ##8 done)
    else $error("transfer without result after 8 cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !xfer |-> ##8 !done)
    else $error("result without transfer");

  a_paths_aligned: assert property (@(posedge clk) disable iff (rst)
    per_dv == ev[2])
    else $error("period and end time paths out of step");

  a_coarse_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.end_coarse < TICKS_PER_SEC) && (result.period_coarse < TICKS_PER_SEC))
    else $error("coarse field out of range");

endmodule

`default_nettype wire

[tb/pulse_time_calculator_top_tb.sv]
// pulse_time_calculator_top_tb: self-checking bench for the pulse time calculator
// drives directed and random start times, lengths and periods, and checks each result
// against an internal predictor; depends on ptc_pkg and pulse_time_calculator_top

module pulse_time_calculator_top_tb;
  import ptc_pkg::*;

  localparam bit [63:0] PS_PER_TICK   = 64'd8000;
  localparam bit [63:0] FRAC_STEPS    = 64'd4096;
  localparam bit [63:0] TICKS_PER_SEC_64 = 64'd125000000;
  localparam bit [63:0] PS_PER_SEC    = 64'd1000000000000;
  localparam bit [63:0] SPAN40        = 64'h100_0000_0000;
  localparam bit [63:0] SPAN44        = 64'h1000_0000_0000;
  localparam int        RANDOM_ITEMS  = 1700;
  localparam int        CALM_TAIL     = 200;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  ptc_in_t  item = '0;
  logic     done;
  ptc_out_t result;

  ptc_in_t  pending_items[$];
  ptc_out_t expected_results[$];
  ptc_out_t want;
  logic     taken = 1'b0;
  int       total_items = 1 << 30;
  int       sent = 0;
  int       accepted = 0;
  int       checked = 0;
  int       mismatches = 0;
  int       wide_items = 0;
  int       idle_left = 0;
  int       idle_pct = 20;

  pulse_time_calculator_top u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic ptc_out_t calc_pulse_times(ptc_in_t x);
    ptc_out_t  r;
    bit [63:0] secs, ticks, frac, len, per, add_ticks, add_frac, rem, psec;
    secs = x.start_seconds;
    ticks = x.start_coarse;
    frac = x.start_fraction;
    len = x.length_ps;
    per = x.period_ps;
    add_ticks = len / PS_PER_TICK;
    add_frac = ((len % PS_PER_TICK) * FRAC_STEPS) / PS_PER_TICK;
    frac = frac + add_frac;
    if (frac >= FRAC_STEPS) begin
      frac = frac - FRAC_STEPS;
      add_ticks = add_ticks + 1;
    end
    ticks = ticks + add_ticks;
    repeat (2) begin
      if (ticks >= TICKS_PER_SEC_64) begin
        ticks = ticks - TICKS_PER_SEC_64;
        secs = secs + 1;
      end
    end
    psec = per / PS_PER_SEC;
    rem = per % PS_PER_SEC;
    r.end_seconds = secs[39:0];
    r.end_coarse = ticks[26:0];
    r.end_fraction = frac[11:0];
    r.period_seconds = psec[3:0];
    add_ticks = rem / PS_PER_TICK;
    add_frac = ((rem % PS_PER_TICK) * FRAC_STEPS) / PS_PER_TICK;
    r.period_coarse = add_ticks[26:0];
    r.period_fraction = add_frac[11:0];
    return r;
  endfunction

  function automatic bit [63:0] rand_below(bit [63:0] n);
    return {$urandom, $urandom} % n;
  endfunction

  task automatic queue_item(bit [63:0] secs, bit [63:0] ticks, bit [63:0] frac,
                            bit [63:0] len, bit [63:0] per);
    ptc_in_t x;
    x.start_seconds = secs[39:0];
    x.start_coarse = ticks[26:0];
    x.start_fraction = frac[11:0];
    x.length_ps = len[39:0];
    x.period_ps = per[43:0];
    if (ticks >= TICKS_PER_SEC_64 || len >= PS_PER_SEC || per >= 16 * PS_PER_SEC)
      wide_items++;
    pending_items.push_back(x);
  endtask

  task automatic queue_random_item();
    bit [63:0] secs, ticks, frac, len, per;
    case ($urandom_range(7, 0))
      0:       secs = SPAN40 - 1 - $urandom_range(3, 0);
      1:       secs = $urandom_range(3, 0);
      default: secs = rand_below(SPAN40);
    endcase
    case ($urandom_range(15, 0))
      0:       ticks = TICKS_PER_SEC_64 + rand_below(64'd134217728 - TICKS_PER_SEC_64);
      1, 2:    ticks = TICKS_PER_SEC_64 - 1 - $urandom_range(15, 0);
      default: ticks = rand_below(TICKS_PER_SEC_64);
    endcase
    case ($urandom_range(7, 0))
      0:       frac = $urandom_range(1, 0) ? 64'd4095 : 64'd0;
      default: frac = $urandom_range(4095, 0);
    endcase
    case ($urandom_range(15, 0))
      0:       len = rand_below(SPAN40);
      1:       len = PS_PER_SEC - 1 - $urandom_range(8000, 0);
      2, 3:    len = rand_below(TICKS_PER_SEC_64) * PS_PER_TICK + $urandom_range(2, 0) * 3999;
      default: len = rand_below(PS_PER_SEC);
    endcase
    case ($urandom_range(15, 0))
      0:       per = rand_below(SPAN44);
      1, 2:    per = $urandom_range(16, 1) * PS_PER_SEC - 4000 + $urandom_range(8000, 0);
      default: per = rand_below(16 * PS_PER_SEC);
    endcase
    queue_item(secs, ticks, frac, len, per);
  endtask

  // driver: one transfer offered per cycle unless idling
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // hold until transfer
    end else if (idle_left > 0) begin
      idle_left--;
      start <= 1'b0;
    end else if (pending_items.size() == 0) begin
      start <= 1'b0;
    end else if (sent < total_items - CALM_TAIL && $urandom_range(99, 0) < idle_pct) begin
      idle_left = $urandom_range(16, 0);
      start <= 1'b0;
    end else begin
      item <= pending_items.pop_front();
      start <= 1'b1;
      sent++;
      if (sent % 128 == 0) begin
        case ($urandom_range(2, 0))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 40;
        endcase
      end
    end
  end

  // monitor: record transfers, compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (done === 1'b1) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no transfer outstanding", $realtime);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (result.end_seconds !== want.end_seconds || result.end_coarse !== want.end_coarse ||
              result.end_fraction !== want.end_fraction ||
              result.period_seconds !== want.period_seconds ||
              result.period_coarse !== want.period_coarse ||
              result.period_fraction !== want.period_fraction) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch on result %0d", $realtime, checked);
              $display("  exp end %0d.%0d.%0d period %0d.%0d.%0d", want.end_seconds,
                       want.end_coarse, want.end_fraction, want.period_seconds,
                       want.period_coarse, want.period_fraction);
              $display("  got end %0d.%0d.%0d period %0d.%0d.%0d", result.end_seconds,
                       result.end_coarse, result.end_fraction, result.period_seconds,
                       result.period_coarse, result.period_fraction);
            end
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(calc_pulse_times(item));
        accepted++;
      end
    end
  end

  initial begin
    queue_item(0, 0, 0, 0, 0);
    queue_item(SPAN40 - 1, 124999999, 4095, 999999999999, 15999999999999);
    queue_item(5, 1000, 4095, 7999, 1);
    queue_item(5, 1000, 4095, 2, 7999);
    queue_item(7, 124999999, 0, 8000, 8000);
    queue_item(7, 124999998, 0, 8000, PS_PER_SEC - 1);
    queue_item(9, 124999999, 1, 7999, PS_PER_SEC);
    queue_item(SPAN40 - 1, 124999999, 0, 8000, 16 * PS_PER_SEC - 1);
    queue_item(SPAN40 - 1, 134217727, 4095, SPAN40 - 1, 16 * PS_PER_SEC);
    queue_item(3, 134217727, 0, 0, SPAN44 - 1);
    queue_item(3, 0, 0, SPAN40 - 1, 15 * PS_PER_SEC + 8000);
    queue_item(64'hAA_AAAA_AAAA, 27'h555_5555, 12'hAAA, 64'h55_5555_5555, 64'hAAA_AAAA_AAAA);
    queue_item(64'h55_5555_5555, 27'h2AA_AAAA, 12'h555, 64'hAA_AAAA_AAAA, 64'h555_5555_5555);
    queue_item(1, 62500000, 2048, 500000000000, 2 * PS_PER_SEC + 4000);
    queue_item(2, 124999999, 4095, 999999999999, 17 * PS_PER_SEC);
    repeat (RANDOM_ITEMS) queue_random_item();
    total_items = pending_items.size();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (pending_items.size() == 0 && accepted == total_items);
    wait (expected_results.size() == 0);
    repeat (16) @(posedge clk);
    $display("%0d transfers, %0d results checked, %0d mismatches", accepted, checked,
             mismatches);
    $display("%0d items carried coarse, length or period past the nominal range", wide_items);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[pulse_time_calculator_top] OK");
    end else begin
      $display("[pulse_time_calculator_top] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout: %0d of %0d transfers, %0d results", accepted, total_items, checked);
    $display("[pulse_time_calculator_top] ERROR");
    $finish;
  end

endmodule
